@@ design/pps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// shared constants, register codes and header offset types of the packet
// payload scrambler
// ----------------------------------------------------------------------------
package pps_pkg;

  // bytes in one packet (range 8 to 32)
  localparam int PACKET_BYTES = 28;

  // byte position and header offsets: offsets reach 18, positions reach 27 (the width holds up to 31)
  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

  localparam logic [7:0] CHAIN_SEED = 8'h23;
  localparam logic [3:0] SHIFT_WRAP = 4'd11;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_NIB_TAB = 2'd1,
    CFG_BYTE_LO = 2'd2,
    CFG_BYTE_HI = 2'd3
  } cfg_idx_t;

  // header layout worked out from the two flag bytes
  typedef struct packed {
    logic             has_addr;  // source address present
    logic             addr_hi;   // address has a second byte
    logic [POS_W-1:0] aoff;      // address low byte position
    logic [POS_W-1:0] tpos;      // timing byte position
    logic [POS_W-1:0] ppos;      // first payload byte position
  } offs_t;

endpackage : pps_pkg
`default_nettype wire

@@ design/pps_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps channel interfaces
// valid/ready channels for packet bytes, result bytes and register writes
// ----------------------------------------------------------------------------
interface pps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface : pps_in_if

interface pps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_payload;
  logic       last;

  modport source (output valid, output out_byte, output is_payload, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input is_payload, input last,
                  output ready);
endinterface : pps_out_if

interface pps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : pps_cfg_if
`default_nettype wire

@@ design/pps_offsets.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_offsets
// decodes source and destination flag bytes into header field positions
// ----------------------------------------------------------------------------
module pps_offsets
  import pps_pkg::*;
(
  input  wire logic [7:0] src_flags,
  input  wire logic [7:0] dst_flags,
  output offs_t           offs
);

  logic [1:0]       st;
  logic [1:0]       dt;
  logic [2:0]       sal;
  logic [2:0]       dal;
  logic [3:0]       dsum;
  logic [POS_W-1:0] hdr;
  logic [POS_W-1:0] tail_t;
  logic [POS_W-1:0] tail_p;

  always_comb begin
    st   = src_flags[1:0];
    dt   = dst_flags[1:0];
    sal  = (st != 2'd0) ? ({1'b0, src_flags[3:2]} + 3'd1) : 3'd0;
    dal  = (dt != 2'd0) ? ({1'b0, dst_flags[3:2]} + 3'd1) : 3'd0;
    dsum = {2'b00, dt} + {1'b0, dal};
    hdr  = POS_W'(st) + POS_W'(sal);

    // destination block adds its length plus one or two extra bytes
    if (dsum != 4'd0) begin
      tail_t = POS_W'(dsum) + POS_W'(1);
      tail_p = POS_W'(dsum) + (dst_flags[4] ? POS_W'(2) : POS_W'(1));
    end else begin
      tail_t = '0;
      tail_p = '0;
    end

    offs.has_addr = (st != 2'd0);
    offs.addr_hi  = (sal >= 3'd2);
    offs.aoff     = POS_W'(st) + POS_W'(1) + POS_W'(src_flags[7]);
    offs.tpos     = hdr + tail_t + POS_W'(1);
    offs.ppos     = hdr + tail_p + POS_W'(2);
  end

endmodule : pps_offsets
`default_nettype wire

@@ design/pps_keystream.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_keystream
// key byte from the two key tables, timing nibble, address shift and chain
// ----------------------------------------------------------------------------
module pps_keystream (
  input  wire logic [63:0] nib_tab,
  input  wire logic [63:0] btab_lo,
  input  wire logic [63:0] btab_hi,
  input  wire logic [3:0]  timing,
  input  wire logic [3:0]  ash_low,
  input  wire logic [7:0]  chain,
  output logic      [7:0]  key
);

  logic [3:0] nib;
  logic [3:0] idx;
  logic [7:0] tab_byte;

  always_comb begin
    nib      = nib_tab[{timing, 2'b00} +: 4];
    idx      = nib + ash_low;
    tab_byte = idx[3] ? btab_hi[{idx[2:0], 3'b000} +: 8]
                      : btab_lo[{idx[2:0], 3'b000} +: 8];
    key      = tab_byte ^ chain;
  end

endmodule : pps_keystream
`default_nettype wire

@@ design/packet_payload_scrambler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packet_payload_scrambler
// header-aware payload scrambler / descrambler for fixed-length radio packets
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle while the output is not stalled and
// returns one result byte per input byte: the byte is captured in an input
// register, transformed by one pass of combinational logic and held in a
// result register; output ready reaches input ready combinationally. The
// rate is set by the chain byte, which feeds each payload byte's key from
// the previous byte and closes within that single pass.
// Byte 0 (or any byte with first set) starts a new packet. The flag bytes
// locate the source address, timing byte and payload start; header bytes
// come out unchanged and payload bytes are scrambled (mode 1) or
// descrambled (mode 0). After the last byte the position wraps to byte 0.
// Register writes (mode, nibble table, byte table low/high) take effect at
// once and are meant to happen while no item is in flight.
// ----------------------------------------------------------------------------
module packet_payload_scrambler
  import pps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  pps_in_if.sink    in_item,
  pps_out_if.source out_item,
  pps_cfg_if.sink   cfg_wr
);

  // configuration registers
  logic        mode_r;
  logic [63:0] nib_tab_r;
  logic [63:0] btab_lo_r;
  logic [63:0] btab_hi_r;

  // input stage
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_first_r;

  // result stage
  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic       out_pay_r;
  logic       out_last_r;

  // per-packet state
  logic [POS_W-1:0] pos_r;
  logic [7:0]       sflags_r;
  logic [7:0]       dflags_r;
  logic [15:0]      addr_r;
  logic [3:0]       tn_r;
  logic [3:0]       shcnt_r;
  logic [15:0]      ash_r;
  logic [7:0]       chain_r;

  // next values
  logic [POS_W-1:0] pos_nxt;
  logic [7:0]       sflags_nxt;
  logic [7:0]       dflags_nxt;
  logic [15:0]      addr_nxt;
  logic [3:0]       tn_nxt;
  logic [3:0]       shcnt_nxt;
  logic [15:0]      ash_nxt;
  logic [7:0]       chain_nxt;
  logic [7:0]       res_nxt;
  logic             pay_nxt;
  logic             last_nxt;

  // datapath helpers
  logic             move;
  logic [POS_W-1:0] pos;
  offs_t            offs;
  logic [3:0]       tn_base;
  logic [2:0]       off_ld;
  logic [2:0]       sh_ld;
  logic [3:0]       tn_eff;
  logic [3:0]       sh_eff;
  logic [15:0]      ash_eff;
  logic [7:0]       chain_eff;
  logic [7:0]       key;

  // an item leaves the input stage when the result stage is free or draining
  assign move           = in_v_r && (!out_v_r || out_item.ready);
  assign in_item.ready  = !in_v_r || move;
  assign cfg_wr.ready   = 1'b1;

  assign out_item.valid      = out_v_r;
  assign out_item.out_byte   = out_byte_r;
  assign out_item.is_payload = out_pay_r;
  assign out_item.last       = out_last_r;

  pps_offsets u_offsets (
    .src_flags (sflags_nxt),
    .dst_flags (dflags_nxt),
    .offs      (offs)
  );

  pps_keystream u_keystream (
    .nib_tab (nib_tab_r),
    .btab_lo (btab_lo_r),
    .btab_hi (btab_hi_r),
    .timing  (tn_eff),
    .ash_low (ash_eff[3:0]),
    .chain   (chain_eff),
    .key     (key)
  );

  always_comb begin
    pos = in_first_r ? '0 : pos_r;

    // flag bytes; a new packet clears the per-packet state and seeds the chain
    sflags_nxt = sflags_r;
    dflags_nxt = dflags_r;
    addr_nxt   = addr_r;
    tn_base    = tn_r;
    shcnt_nxt  = shcnt_r;
    ash_nxt    = ash_r;
    chain_nxt  = chain_r;
    if (pos == '0) begin
      sflags_nxt = in_byte_r;
      dflags_nxt = '0;
      addr_nxt   = '0;
      tn_base    = '0;
      shcnt_nxt  = '0;
      ash_nxt    = '0;
      chain_nxt  = CHAIN_SEED;
    end else if (pos == POS_W'(1)) begin
      dflags_nxt = sflags_r[7] ? in_byte_r : 8'h00;
    end

    // header capture; one byte may be both address and timing byte
    if (offs.has_addr && pos == offs.aoff) begin
      addr_nxt[7:0] = in_byte_r;
    end
    if (offs.has_addr && offs.addr_hi && pos == offs.aoff + POS_W'(1)) begin
      addr_nxt[15:8] = in_byte_r;
    end
    tn_nxt = (pos == offs.tpos) ? in_byte_r[3:0] : tn_base;

    // key schedule loads from the address on the first payload byte
    off_ld = {addr_nxt[7], addr_nxt[13], addr_nxt[10]};
    sh_ld  = {addr_nxt[12], addr_nxt[3], addr_nxt[15]};
    if (pos == offs.ppos) begin
      tn_eff    = tn_nxt + {1'b0, off_ld};
      sh_eff    = {1'b0, sh_ld};
      ash_eff   = addr_nxt >> sh_ld;
      chain_eff = CHAIN_SEED;
    end else begin
      tn_eff    = tn_nxt;
      sh_eff    = shcnt_nxt;
      ash_eff   = ash_nxt;
      chain_eff = chain_nxt;
    end

    pay_nxt  = (pos >= offs.ppos);
    last_nxt = (pos == LAST_POS);
    res_nxt  = in_byte_r;

    if (pay_nxt) begin
      if (mode_r) begin
        res_nxt   = in_byte_r + key;
        chain_nxt = res_nxt;
      end else begin
        res_nxt   = in_byte_r - key;
        chain_nxt = in_byte_r;
      end
      tn_nxt = tn_eff + 4'd1;
      // address shift walks down, then reloads from the address
      if (sh_eff <= SHIFT_WRAP) begin
        shcnt_nxt = sh_eff + 4'd1;
        ash_nxt   = ash_eff >> 1;
      end else begin
        shcnt_nxt = '0;
        ash_nxt   = addr_nxt;
      end
    end

    pos_nxt = (pos == LAST_POS) ? '0 : pos + POS_W'(1);
  end

  // control, state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      pos_r     <= '0;
      sflags_r  <= '0;
      dflags_r  <= '0;
      addr_r    <= '0;
      tn_r      <= '0;
      shcnt_r   <= '0;
      ash_r     <= '0;
      chain_r   <= CHAIN_SEED;
      mode_r    <= 1'b0;
      nib_tab_r <= '0;
      btab_lo_r <= '0;
      btab_hi_r <= '0;
    end else begin
      if (in_item.ready) begin
        in_v_r <= in_item.valid;
      end
      if (move) begin
        out_v_r  <= 1'b1;
        pos_r    <= pos_nxt;
        sflags_r <= sflags_nxt;
        dflags_r <= dflags_nxt;
        addr_r   <= addr_nxt;
        tn_r     <= tn_nxt;
        shcnt_r  <= shcnt_nxt;
        ash_r    <= ash_nxt;
        chain_r  <= chain_nxt;
      end else if (out_item.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_wr.valid) begin
        unique case (cfg_idx_t'(cfg_wr.index))
          CFG_MODE:    mode_r    <= cfg_wr.data[0];
          CFG_NIB_TAB: nib_tab_r <= cfg_wr.data;
          CFG_BYTE_LO: btab_lo_r <= cfg_wr.data;
          CFG_BYTE_HI: btab_hi_r <= cfg_wr.data;
          default:     mode_r    <= mode_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_item.ready && in_item.valid) begin
      in_byte_r  <= in_item.data_byte;
      in_first_r <= in_item.first;
    end
    if (move) begin
      out_byte_r <= res_nxt;
      out_pay_r  <= pay_nxt;
      out_last_r <= last_nxt;
    end
  end

endmodule : packet_payload_scrambler
`default_nettype wire

@@ dv/scrambler_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrambler_check
// watches the byte, result and register channels of the payload scrambler,
// predicts every result byte and compares it with what comes out
// ----------------------------------------------------------------------------
module scrambler_check
  import pps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pps_in_if    in_mon,
  pps_out_if   out_mon,
  pps_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_payload;
    logic       last;
  } byte_result_t;

  // register copies
  logic         scramble_mode;
  logic [63:0]  nib_tab;
  logic [127:0] byte_tab;  // {high half, low half}

  // per-packet header and keystream state
  logic [POS_W-1:0] pkt_pos;
  logic [7:0]       src_flags;
  logic [7:0]       dst_flags;
  logic [15:0]      src_addr;
  logic [3:0]       timing_nib;
  logic [3:0]       sh_cnt;
  logic [15:0]      addr_sh;
  logic [7:0]       chain;

  byte_result_t expected_bytes[$];

  function automatic byte_result_t predict_byte(logic [7:0] d, logic first);
    int unsigned  pos, st, sal, dt, dal, dsum, aoff, tpos, ppos;
    logic [2:0]   t_off;
    logic [3:0]   kidx;
    logic [7:0]   key;
    byte_result_t r;
    pos = first ? 0 : pkt_pos;
    if (pos >= PACKET_BYTES) pos = 0;
    if (pos == 0) begin
      src_flags  = d;
      dst_flags  = '0;
      src_addr   = '0;
      timing_nib = '0;
      sh_cnt     = '0;
      addr_sh    = '0;
      chain      = CHAIN_SEED;
    end else if (pos == 1) begin
      dst_flags = src_flags[7] ? d : 8'h00;
    end
    st   = src_flags[1:0];
    sal  = (st != 0) ? src_flags[3:2] + 1 : 0;
    dt   = dst_flags[1:0];
    dal  = (dt != 0) ? dst_flags[3:2] + 1 : 0;
    dsum = dt + dal;
    aoff = st + 1 + src_flags[7];
    tpos = st + sal + ((dsum != 0) ? dsum + 1 : 0) + 1;
    ppos = st + sal + ((dsum != 0) ? dsum + (dst_flags[4] ? 2 : 1) : 0) + 2;
    // an address byte may also be the timing byte
    if (st != 0 && pos == aoff) src_addr[7:0] = d;
    if (st != 0 && sal >= 2 && pos == aoff + 1) src_addr[15:8] = d;
    if (pos == tpos) timing_nib = d[3:0];
    r.out_byte   = d;
    r.is_payload = 1'b0;
    if (pos >= ppos) begin
      r.is_payload = 1'b1;
      if (pos == ppos) begin
        t_off      = {src_addr[7], src_addr[13], src_addr[10]};
        sh_cnt     = {1'b0, src_addr[12], src_addr[3], src_addr[15]};
        addr_sh    = src_addr >> sh_cnt;
        timing_nib = timing_nib + t_off;
        chain      = CHAIN_SEED;
      end
      kidx = nib_tab[4*timing_nib +: 4] + addr_sh[3:0];
      key  = byte_tab[8*kidx +: 8] ^ chain;
      if (scramble_mode) begin
        r.out_byte = d + key;
        chain      = r.out_byte;
      end else begin
        r.out_byte = d - key;
        chain      = d;
      end
      timing_nib = timing_nib + 4'd1;
      if (sh_cnt <= SHIFT_WRAP) begin
        sh_cnt  = sh_cnt + 4'd1;
        addr_sh = addr_sh >> 1;
      end else begin
        sh_cnt  = '0;
        addr_sh = src_addr;
      end
    end
    r.last  = (pos == PACKET_BYTES - 1);
    pkt_pos = (pos + 1 >= PACKET_BYTES) ? '0 : POS_W'(pos + 1);
    return r;
  endfunction

  always @(posedge clk) begin
    byte_result_t want, got;
    if (!rst_n) begin
      scramble_mode = 1'b0;
      nib_tab       = '0;
      byte_tab      = '0;
      pkt_pos       = '0;
      src_flags     = '0;
      dst_flags     = '0;
      src_addr      = '0;
      timing_nib    = '0;
      sh_cnt        = '0;
      addr_sh       = '0;
      chain         = CHAIN_SEED;
      fail_count    = 0;
      expected_bytes.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_MODE:    scramble_mode    = cfg_mon.data[0];
          CFG_NIB_TAB: nib_tab          = cfg_mon.data;
          CFG_BYTE_LO: byte_tab[63:0]   = cfg_mon.data;
          CFG_BYTE_HI: byte_tab[127:64] = cfg_mon.data;
          default: ;
        endcase
      end
      // compare before queuing so a result can never match its own byte
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.out_byte, out_mon.is_payload, out_mon.last};
        if (expected_bytes.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: unexpected result byte=%02h payload=%0b last=%0b",
                     $time, got.out_byte, got.is_payload, got.last);
        end else begin
          want = expected_bytes.pop_front();
          if (want.out_byte !== got.out_byte || want.is_payload !== got.is_payload ||
              want.last !== got.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: result mismatch exp byte=%02h payload=%0b last=%0b, got byte=%02h payload=%0b last=%0b",
                       $time, want.out_byte, want.is_payload, want.last,
                       got.out_byte, got.is_payload, got.last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_bytes.push_back(predict_byte(in_mon.data_byte, in_mon.first));
    end
    pending = expected_bytes.size();
  end

endmodule : scrambler_check

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives packets through the payload scrambler under several table and mode
// settings, with random gaps and stalls and one long output hold-off
// ----------------------------------------------------------------------------
module tb;
  import pps_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving anywhere
  localparam int HOLD_CYCLES    = 300;   // long output hold-off
  localparam int HOLD_AT        = 600;   // items sent before the hold-off starts
  localparam int QUIET_FROM     = 900;   // window with no idling on either side
  localparam int QUIET_TO       = 1250;
  localparam int PHASE_ITEMS    = 250;
  localparam int PHASES         = 7;
  localparam int SETTLE_CYCLES  = 4;     // pipeline is two deep, plus margin

  // directed bytes, {first, data}
  localparam int DIRECTED_LEN = 18;
  localparam logic [8:0] DIRECTED [DIRECTED_LEN] = '{
    // address low byte doubles as timing byte, payload from byte 4
    9'h181, 9'h000, 9'h0ff, 9'h034, 9'h000, 9'h0ff, 9'h080,
    // no source address, timing byte 1, payload from byte 2
    9'h100, 9'h0ff, 9'h000, 9'h0ff, 9'h001,
    // deepest header: every flag bit set, payload would start at byte 18
    9'h1ff, 9'h0ff, 9'h000, 9'h0ff, 9'h055, 9'h0aa
  };

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sent_items;
  int   idle_cycles;
  bit   at_pkt_start;  // previous packet ran to its last byte
  logic quiet;

  pps_in_if  in_bus();
  pps_out_if out_bus();
  pps_cfg_if cfg_bus();

  packet_payload_scrambler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_bus),
    .out_item (out_bus),
    .cfg_wr   (cfg_bus)
  );

  scrambler_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no idling on either side through this window
  assign quiet = (sent_items >= QUIET_FROM) && (sent_items < QUIET_TO);

  // one item per call; entered and left at a falling edge, valid left high
  task automatic send_byte(input logic [7:0] d, input logic f);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= d;
    in_bus.first     <= f;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    sent_items++;
  endtask

  // a packet of nbytes bytes, flag bytes given, payload random
  task automatic send_packet(input logic [7:0] src, input logic [7:0] dst,
                             input logic f0, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if (i == 0) send_byte(src, f0);
      else if (i == 1) send_byte(dst, 1'b0);
      else send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic run_random(input int n);
    int         done_items;
    int         len;
    logic [7:0] src;
    logic [7:0] dst;
    logic       f0;
    done_items = 0;
    while (done_items < n) begin
      src = 8'($urandom_range(0, 255));
      dst = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 20) begin
        // one-byte address with dest flags present: timing byte lands on it
        src[7]   = 1'b1;
        src[3:2] = 2'b00;
        dst[1:0] = 2'b00;
      end else if ($urandom_range(0, 99) < 10) begin
        // longest header
        src[7]   = 1'b1;
        src[3:0] = 4'hf;
        dst[4:0] = 5'h1f;
      end
      // mostly whole packets; the rest are cut short and restarted
      len = ($urandom_range(0, 99) < 80) ? PACKET_BYTES : $urandom_range(1, PACKET_BYTES - 1);
      // after a whole packet the position wraps, so first may be left low
      f0 = !(at_pkt_start && $urandom_range(0, 99) < 15);
      send_packet(src, dst, f0, len);
      at_pkt_start = (len == PACKET_BYTES);
      done_items += len;
    end
  endtask

  // register write; valid stays high so back-to-back writes need no drop
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic mode_bit, input bit all_ones);
    logic [63:0] tab [3];
    for (int i = 0; i < 3; i++) tab[i] = all_ones ? '1 : {$urandom, $urandom};
    write_reg(CFG_MODE, 64'(mode_bit));
    write_reg(CFG_NIB_TAB, tab[0]);
    write_reg(CFG_BYTE_LO, tab[1]);
    write_reg(CFG_BYTE_HI, tab[2]);
    cfg_bus.valid <= 1'b0;
  endtask

  // stop offering and let every outstanding result drain
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side: random stalls, one long hold-off while the sender keeps going
  initial begin : out_ready_drive
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_items >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= quiet || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // watchdog: too long with nothing accepted on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // every input known from time zero
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = '0;
    in_bus.first      = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_MODE;
    cfg_bus.data      = '0;
    out_bus.ready     = 1'b0;
    sent_items        = 0;
    idle_cycles       = 0;
    at_pkt_start      = 1'b1;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: descramble with all-zero tables
    for (int i = 0; i < DIRECTED_LEN; i++) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    at_pkt_start = 1'b0;
    run_random(PHASE_ITEMS);

    // later phases alternate the mode; all-ones tables in two of them
    for (int ph = 1; ph < PHASES; ph++) begin
      settle();
      load_settings(ph[0], (ph == 1) || (ph == 4));
      run_random(PHASE_ITEMS);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule : tb

@@ sim.f @@
design/pps_pkg.sv
design/pps_if.sv
design/pps_offsets.sv
design/pps_keystream.sv
design/packet_payload_scrambler.sv
dv/scrambler_check.sv
dv/tb.sv
